### hw/rtl/awbd_pkg.sv
// Package for the alpha weighted box downsample unit.
// Holds shared types, state codes and constants; no dependencies.
package awbd_pkg;

  localparam int unsigned NormNum  = 260100;
  localparam int unsigned NormDen  = 1020;
  // floor(2^28 / 1020): with one correction step this gives floor(p / 1020) for p < 2^28.
  localparam int unsigned RecipDen = 263172;

  localparam logic [0:0] CFG_IMAGE_WIDTH = 1'b0;
  localparam logic [0:0] CFG_QUADRANT    = 1'b1;

  typedef enum logic [2:0] {
    NORM_IDLE,
    NORM_DIV,
    NORM_MUL,
    NORM_QUO,
    NORM_OUT
  } norm_state_t;

  typedef struct packed {
    logic [9:0]  r;
    logic [9:0]  g;
    logic [9:0]  b;
    logic [9:0]  a;
    logic [10:0] x;
    logic [10:0] y;
    logic        done;
  } box_sum_t;

  typedef struct packed {
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic [10:0] x;
    logic [10:0] y;
    logic        done;
  } box_res_t;

endpackage

### hw/rtl/awbd_norm.sv
// Normaliser: serial divide for the alpha factor, multiply, divide by 1020.
// Depends on awbd_pkg.
module awbd_norm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  awbd_pkg::box_sum_t  in_sum,
  output logic                busy,
  input  logic                hold,
  output logic                out_valid,
  output awbd_pkg::box_res_t  out_res
);

  awbd_pkg::norm_state_t state_r, state_nxt;
  logic [4:0]         cnt_r;
  awbd_pkg::box_sum_t sum_r;
  logic [9:0]         rem_r;
  logic [17:0]        num_r;
  logic [27:0]        p_r [4];
  awbd_pkg::box_res_t res_r;

  logic [9:0]  ch_sum [4];
  logic [10:0] trial;
  logic        q_bit;
  logic [9:0]  rem_nxt;
  logic [17:0] f;
  logic [7:0]  q8 [4];
  logic [46:0] qm [4];
  logic [18:0] qt [4];
  logic [27:0] rem [4];

  assign ch_sum[0] = sum_r.r;
  assign ch_sum[1] = sum_r.g;
  assign ch_sum[2] = sum_r.b;
  assign ch_sum[3] = sum_r.a;

  // One restoring step of 260100 / alpha_sum per cycle; the quotient shifts into num_r.
  assign trial   = {rem_r, num_r[17]};
  assign q_bit   = (trial >= {1'b0, sum_r.a});
  assign rem_nxt = q_bit ? 10'(trial - {1'b0, sum_r.a}) : trial[9:0];
  assign f       = (sum_r.a == 10'd0) ? '0 : num_r;

  // p < 2^28; q = floor(p/1020) via reciprocal then one correction.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qm[i] = 47'(p_r[i]) * 47'(awbd_pkg::RecipDen);
      qt[i] = qm[i][46:28];
      rem[i] = p_r[i] - 28'(qt[i]) * 28'(awbd_pkg::NormDen);
      if (rem[i] >= 28'(awbd_pkg::NormDen)) begin
        qt[i] = qt[i] + 19'd1;
      end
      q8[i] = qt[i][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= awbd_pkg::NORM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      awbd_pkg::NORM_IDLE: if (in_valid) state_nxt = awbd_pkg::NORM_DIV;
      awbd_pkg::NORM_DIV:  if (cnt_r == 5'd17) state_nxt = awbd_pkg::NORM_MUL;
      awbd_pkg::NORM_MUL:  state_nxt = awbd_pkg::NORM_QUO;
      awbd_pkg::NORM_QUO:  state_nxt = awbd_pkg::NORM_OUT;
      awbd_pkg::NORM_OUT:  if (!hold) state_nxt = awbd_pkg::NORM_IDLE;
      default:             state_nxt = awbd_pkg::NORM_IDLE;
    endcase
    busy      = (state_r != awbd_pkg::NORM_IDLE);
    out_valid = (state_r == awbd_pkg::NORM_OUT);
  end

  always_ff @(posedge clk) begin
    case (state_r)
      awbd_pkg::NORM_IDLE: begin
        sum_r <= in_sum;
        num_r <= 18'(awbd_pkg::NormNum);
        rem_r <= '0;
        cnt_r <= '0;
      end
      awbd_pkg::NORM_DIV: begin
        num_r <= {num_r[16:0], q_bit};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 5'd1;
      end
      awbd_pkg::NORM_MUL: begin
        for (int i = 0; i < 4; i++) begin
          p_r[i] <= 28'(ch_sum[i]) * 28'(f);
        end
      end
      awbd_pkg::NORM_QUO: begin
        res_r <= '{r: q8[0], g: q8[1], b: q8[2], a: q8[3],
                   x: sum_r.x, y: sum_r.y, done: sum_r.done};
      end
      default: ;
    endcase
  end

  assign out_res = res_r;

endmodule

### hw/rtl/alpha_weighted_box_downsample_unit.sv
// Top level of the alpha weighted box downsample unit.
// Order: a block's sums are registered in stage A, then the normaliser divides, multiplies and forms the quotient.
// Throughput: one pixel per cycle, except that the normaliser works on one block at a time,
// so a block closed on an odd row stalls the input while its predecessor is in work.
// Reset: counts, held pixel, stage A valid, config and normaliser state reset; the line memory
// is not cleared, every entry being written on an even row before the odd row reads it.
module alpha_weighted_box_downsample_unit #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic [7:0]  in_alpha_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic [7:0]  out_alpha_out,
  output logic [10:0] out_out_x,
  output logic [10:0] out_out_y,
  output logic        out_image_done,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int unsigned Depth = MAX_WIDTH / 2;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(MAX_WIDTH + 1);

  logic [11:0]   width_r;
  logic [1:0]    quad_r;
  logic [CW-1:0] col_r, row_r;
  logic [31:0]   held_r;
  logic [35:0]   line_mem [Depth];
  logic [35:0]   rd_q_r;

  // Stage A registers: pair sums of the odd-row pair, registered alongside the memory read.
  logic          a_valid_r;
  logic [8:0]    a_s_r [4];
  logic [10:0]   a_x_r, a_y_r;
  logic          a_done_r;

  logic [CW-1:0] w_eff, half;
  logic [7:0]    px [4];
  logic [8:0]    ps [4];
  logic          take, in_img, odd_col, odd_row;
  logic [AW-1:0] idx;
  logic [CW-1:0] bx, by;

  logic          n_valid;
  logic          n_busy;
  awbd_pkg::box_sum_t sum_in;
  awbd_pkg::box_res_t res;

  always_comb begin
    if (width_r < 12'd2) w_eff = CW'(2);
    else if (32'(width_r) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(width_r);
  end
  assign half = w_eff >> 1;

  assign px[0] = in_red_in;
  assign px[1] = in_green_in;
  assign px[2] = in_blue_in;
  assign px[3] = in_alpha_in;
  always_comb begin
    for (int i = 0; i < 4; i++) ps[i] = 9'(held_r[8*i +: 8]) + 9'(px[i]);
  end

  assign in_stall = a_valid_r && n_busy;
  assign take     = in_valid && !in_stall;
  assign in_img   = (col_r < (half << 1)) && (row_r < (half << 1));
  assign odd_col  = col_r[0];
  assign odd_row  = row_r[0];
  assign idx      = AW'(col_r >> 1);
  assign bx       = (col_r >> 1) + (quad_r[0] ? half : '0);
  assign by       = (row_r >> 1) + (quad_r[1] ? half : '0);

  always_ff @(posedge clk) begin
    if (take && in_img && odd_col) begin
      if (!odd_row) begin
        line_mem[idx] <= {ps[3], ps[2], ps[1], ps[0]};
      end else begin
        rd_q_r <= line_mem[idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= 12'd2048;
      quad_r    <= 2'd0;
      col_r     <= '0;
      row_r     <= '0;
      held_r    <= '0;
      a_valid_r <= 1'b0;
    end else begin
      if (!n_busy) a_valid_r <= 1'b0;
      if (take) begin
        if (in_img && !odd_col) held_r <= {px[3], px[2], px[1], px[0]};
        if (in_img && odd_col && odd_row) a_valid_r <= 1'b1;
        if (col_r + 1'b1 >= w_eff) begin
          col_r <= '0;
          row_r <= (row_r + 1'b1 >= w_eff) ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          awbd_pkg::CFG_IMAGE_WIDTH: width_r <= cfg_data;
          awbd_pkg::CFG_QUADRANT:    quad_r  <= cfg_data[1:0];
          default: ;
        endcase
        col_r <= '0;
        row_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_img && odd_col && odd_row) begin
      for (int i = 0; i < 4; i++) a_s_r[i] <= ps[i];
      a_x_r    <= 11'(bx);
      a_y_r    <= 11'(by);
      a_done_r <= ((col_r >> 1) == half - 1'b1) && ((row_r >> 1) == half - 1'b1);
    end
  end

  assign n_valid = a_valid_r;
  assign sum_in  = '{r: 10'(a_s_r[0]) + 10'(rd_q_r[8:0]),
                     g: 10'(a_s_r[1]) + 10'(rd_q_r[17:9]),
                     b: 10'(a_s_r[2]) + 10'(rd_q_r[26:18]),
                     a: 10'(a_s_r[3]) + 10'(rd_q_r[35:27]),
                     x: a_x_r, y: a_y_r, done: a_done_r};

  awbd_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (n_valid),
    .in_sum   (sum_in),
    .busy     (n_busy),
    .hold     (out_stall),
    .out_valid(out_valid),
    .out_res  (res)
  );

  assign out_red_out    = res.r;
  assign out_green_out  = res.g;
  assign out_blue_out   = res.b;
  assign out_alpha_out  = res.a;
  assign out_out_x      = res.x;
  assign out_out_y      = res.y;
  assign out_image_done = res.done;

endmodule

### dv/awbd_checker.sv
`timescale 1ns / 1ps
// Checker for the alpha weighted box downsample unit: watches the pixel, result and
// register ports, predicts each result pixel and compares it. Depends on awbd_pkg.
module awbd_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic [7:0]  in_alpha_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_red_out,
  input  logic [7:0]  out_green_out,
  input  logic [7:0]  out_blue_out,
  input  logic [7:0]  out_alpha_out,
  input  logic [10:0] out_out_x,
  input  logic [10:0] out_out_y,
  input  logic        out_image_done,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          pixels_checked
);

  awbd_pkg::box_res_t pixel_queue[$];
  logic [35:0] pair_line[1024];
  logic [11:0] side_reg;
  logic [1:0]  quad_reg;
  int unsigned col_pos;
  int unsigned row_pos;
  logic [31:0] held_px;

  assign pending = pixel_queue.size();

  function automatic int unsigned side_eff();
    int unsigned w;
    w = side_reg;
    if (w < 2) w = 2;
    if (w > 2048) w = 2048;
    return w;
  endfunction

  task automatic downsample_pixel(input logic [31:0] px);
    int unsigned w;
    int unsigned half;
    int unsigned sums[4];
    int unsigned f;
    int unsigned bx;
    int unsigned by;
    logic [35:0] stored;
    awbd_pkg::box_res_t res;
    w = side_eff();
    half = w / 2;
    if (col_pos < 2 * half && row_pos < 2 * half) begin
      if (col_pos[0] == 1'b0) begin
        held_px = px;
      end else begin
        for (int c = 0; c < 4; c++) sums[c] = held_px[8*c +: 8] + px[8*c +: 8];
        if (row_pos[0] == 1'b0) begin
          for (int c = 0; c < 4; c++) stored[9*c +: 9] = sums[c][8:0];
          pair_line[(col_pos >> 1) % 1024] = stored;
        end else begin
          stored = pair_line[(col_pos >> 1) % 1024];
          for (int c = 0; c < 4; c++) sums[c] += stored[9*c +: 9];
          f = (sums[3] > 0) ? awbd_pkg::NormNum / sums[3] : 0;
          res.r = 8'((sums[0] * f) / awbd_pkg::NormDen);
          res.g = 8'((sums[1] * f) / awbd_pkg::NormDen);
          res.b = 8'((sums[2] * f) / awbd_pkg::NormDen);
          res.a = 8'((sums[3] * f) / awbd_pkg::NormDen);
          bx = col_pos >> 1;
          by = row_pos >> 1;
          if (quad_reg[0]) bx += half;
          if (quad_reg[1]) by += half;
          res.x = 11'(bx);
          res.y = 11'(by);
          res.done = ((col_pos >> 1) == half - 1) && ((row_pos >> 1) == half - 1);
          pixel_queue.insert(pixel_queue.size(), res);
        end
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= w) row_pos = 0;
    end
  endtask

  task automatic compare_pixel();
    awbd_pkg::box_res_t exp_px;
    awbd_pkg::box_res_t got;
    got = '{out_red_out, out_green_out, out_blue_out, out_alpha_out,
            out_out_x, out_out_y, out_image_done};
    pixels_checked++;
    if (pixel_queue.size() == 0) begin
      $display("%0t: result transfer with nothing expected, actual %p", $time, got);
      fail_count++;
    end else begin
      exp_px = pixel_queue[0];
      pixel_queue.delete(0);
      if (got !== exp_px) begin
        $display("%0t: result mismatch, expected %p, actual %p", $time, exp_px, got);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      side_reg = 12'd2048;
      quad_reg = '0;
      col_pos = 0;
      row_pos = 0;
      held_px = '0;
      fail_count = 0;
      pixels_checked = 0;
      pixel_queue.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == awbd_pkg::CFG_IMAGE_WIDTH) side_reg = cfg_data;
        else quad_reg = cfg_data[1:0];
        col_pos = 0;
        row_pos = 0;
      end
      if (in_valid && !in_stall) begin
        downsample_pixel({in_alpha_in, in_blue_in, in_green_in, in_red_in});
      end
      if (out_valid && !out_stall) begin
        compare_pixel();
      end
    end
  end

endmodule

### dv/alpha_weighted_box_downsample_unit_tb.sv
`timescale 1ns / 1ps
// Top of the testbench for the alpha weighted box downsample unit: clock, reset,
// pixel and register stimulus, result-side stalls and the verdict. Depends on awbd_checker.
module alpha_weighted_box_downsample_unit_tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_red_in = '0;
  logic [7:0]  in_green_in = '0;
  logic [7:0]  in_blue_in = '0;
  logic [7:0]  in_alpha_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_red_out;
  logic [7:0]  out_green_out;
  logic [7:0]  out_blue_out;
  logic [7:0]  out_alpha_out;
  logic [10:0] out_out_x;
  logic [10:0] out_out_y;
  logic        out_image_done;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = awbd_pkg::CFG_IMAGE_WIDTH;
  logic [11:0] cfg_data = '0;

  int  fail_count;
  int  pending;
  int  pixels_checked;
  int  pixels_sent;
  int  images_run;
  int  cycle_count;
  bit  calm;

  always #1 clk = ~clk;

  alpha_weighted_box_downsample_unit i_dut (.*);

  awbd_checker i_checker (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1000000) begin
      $display("alpha_weighted_box_downsample_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int n;
    forever begin
      n = calm ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  task automatic send_pixel(input logic [31:0] px);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_alpha_in, in_blue_in, in_green_in, in_red_in} <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  function automatic logic [31:0] random_pixel();
    logic [31:0] px;
    px = $urandom;
    case ($urandom_range(0, 7))
      0: px[31:24] = 8'd0;
      1: px[31:24] = 8'($urandom_range(0, 3));
      2: px = 32'hFFFF_FFFF;
      default: ;
    endcase
    return px;
  endfunction

  task automatic write_reg(input logic [0:0] idx, input logic [11:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_image(input logic [11:0] side, input logic [1:0] quad, input int npix);
    settle();
    case ($urandom_range(0, 2))
      0: write_reg(awbd_pkg::CFG_IMAGE_WIDTH, side);
      1: write_reg(awbd_pkg::CFG_QUADRANT, 12'(quad));
      default: begin
        write_reg(awbd_pkg::CFG_IMAGE_WIDTH, side);
        write_reg(awbd_pkg::CFG_QUADRANT, {10'($urandom_range(0, 1023)), quad});
      end
    endcase
    calm = ($urandom_range(0, 5) == 0);
    for (int i = 0; i < npix; i++) send_pixel(random_pixel());
    images_run++;
  endtask

  initial begin
    int w;
    int npix;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(awbd_pkg::CFG_IMAGE_WIDTH, 12'd2);
    write_reg(awbd_pkg::CFG_QUADRANT, 12'd0);
    repeat (4) send_pixel(32'hFFFF_FFFF);
    repeat (4) send_pixel(32'h00FF_FFFF);
    repeat (4) send_pixel(32'h01FF_FFFF);
    send_pixel(32'h0000_0000);
    send_pixel(32'h0000_0000);
    send_pixel(32'h0000_0000);
    send_pixel(32'h0100_0000);
    settle();
    write_reg(awbd_pkg::CFG_IMAGE_WIDTH, 12'd0);
    write_reg(awbd_pkg::CFG_QUADRANT, 12'd3);
    repeat (4) send_pixel(random_pixel());
    settle();
    write_reg(awbd_pkg::CFG_IMAGE_WIDTH, 12'd1);
    repeat (4) send_pixel(random_pixel());
    run_image(12'd3, 2'd1, 9);

    settle();
    write_reg(awbd_pkg::CFG_IMAGE_WIDTH, 12'hFFF);
    write_reg(awbd_pkg::CFG_QUADRANT, 12'd1);
    repeat (24) send_pixel(random_pixel());
    images_run++;

    while (pixels_sent < 1900) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) : $urandom_range(2, 10);
      case ($urandom_range(0, 3))
        0: npix = $urandom_range(1, w * w);
        1: npix = 2 * w * w + $urandom_range(0, w);
        default: npix = w * w;
      endcase
      if (pixels_sent + npix > 1900) npix = 1900 - pixels_sent;
      run_image(12'(w), 2'($urandom_range(0, 3)), npix);
    end

    settle();
    repeat (20) @(posedge clk);
    $display("Ran %0d image settings over %0d pixel transfers; %0d result transfers checked.",
             images_run, pixels_sent, pixels_checked);
    if (fail_count == 0) begin
      $display("alpha_weighted_box_downsample_unit regression: pass");
    end else begin
      $display("alpha_weighted_box_downsample_unit regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/awbd_pkg.sv
hw/rtl/awbd_norm.sv
hw/rtl/alpha_weighted_box_downsample_unit.sv
dv/awbd_checker.sv
dv/alpha_weighted_box_downsample_unit_tb.sv
